@@ hw/rtl/assert_macros.svh @@
// assertion macros for the rtl, used by ppu_back, empty when synthesised
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property checked on every clock edge outside reset
`define PPU_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// consequence checked on the edge after the trigger
`define PPU_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define PPU_ASSERT(lbl, prop)
`define PPU_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

@@ hw/rtl/ppu_pkg.sv @@
// types and constants of the packed pixel unpacker
package ppu_pkg;

    localparam int BYTE_W = 8;
    localparam int BPP_W = 4;
    localparam int PPF_W = 25;
    localparam int PIX_W = 15;
    localparam int BUF_W = 22;
    localparam int HELD_W = 5;
    localparam int CFG_IDX_W = 2;

    localparam logic [PPF_W-1:0] MAX_FRAME_PIXELS = 25'd16777216;
    localparam logic [BPP_W-1:0] BPP_MIN = 4'd9;
    localparam logic [BPP_W-1:0] BPP_MAX = 4'd15;
    localparam logic [BPP_W-1:0] BPP_RESET = 4'd12;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FORMAT_MODE      = 2'd0,
        REG_BITS_PER_PIXEL   = 2'd1,
        REG_PIXELS_PER_FRAME = 2'd2
    } cfg_reg_t;

    typedef enum logic {
        FMT_LSB_FIRST = 1'b0,
        FMT_MONO12P   = 1'b1
    } fmt_mode_t;

    typedef enum logic [1:0] {
        PH_FIRST  = 2'd0,
        PH_SECOND = 2'd1,
        PH_THIRD  = 2'd2
    } pair_phase_t;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              frame_start;
    } byte_item_t;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_value;
        logic             last_pixel;
    } pixel_item_t;

    // handshake between the byte queue and the unpack core
    typedef struct packed {
        logic       valid;
        byte_item_t item;
    } byte_link_t;

endpackage

@@ hw/rtl/ppu_front.sv @@
// front end: accepts raw bytes into a four-entry queue
module ppu_front
    import ppu_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  logic [BYTE_W-1:0]    data_byte,
    input  logic                 frame_start,
    output byte_link_t           link,
    input  logic                 take
);

    localparam int DEPTH = 4;
    localparam int PTR_W = $clog2(DEPTH);

    byte_item_t             mem_reg [DEPTH];
    logic [PTR_W-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]         count_reg, count_next;
    logic                   push_ok;
    logic                   pop_ok;

    assign full = (count_reg == (PTR_W+1)'(DEPTH));
    assign push_ok = push && !full;
    assign pop_ok = take && link.valid;

    assign link.valid = (count_reg != '0);
    assign link.item = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push_ok ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop_ok ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next = count_reg;
        if (push_ok && !pop_ok)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop_ok && !push_ok)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_ok)
        begin
            mem_reg[wr_ptr_reg] <= '{data_byte: data_byte, frame_start: frame_start};
        end
    end

endmodule

@@ hw/rtl/ppu_back.sv @@
// back end: configuration, unpacking and the two-entry pixel queue
`include "assert_macros.svh"

module ppu_back
    import ppu_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  byte_link_t           link,
    output logic                 take,
    input  logic                 cfg_valid,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [PPF_W-1:0]     cfg_data,
    output logic                 empty,
    input  logic                 pop,
    output logic [PIX_W-1:0]     pixel_value,
    output logic                 last_pixel
);

    // configuration
    fmt_mode_t              mode_reg, mode_next;
    logic [BPP_W-1:0]       bpp_reg, bpp_next;
    logic [PPF_W-1:0]       ppf_reg, ppf_next;

    // unpack state
    logic [BUF_W-1:0]       buf_reg, buf_next;
    logic [HELD_W-1:0]      held_reg, held_next;
    pair_phase_t            phase_reg, phase_next;
    logic [PPF_W-1:0]       emitted_reg, emitted_next;

    // output queue
    pixel_item_t            oq_reg [2];
    logic                   oq_wr_reg, oq_wr_next;
    logic                   oq_rd_reg, oq_rd_next;
    logic [1:0]             oq_count_reg, oq_count_next;

    logic                   pop_ok;
    logic                   out_push;
    pixel_item_t            out_item;

    logic [BUF_W-1:0]       buf_base;
    logic [HELD_W-1:0]      held_base;
    pair_phase_t            phase_base;
    logic [PPF_W-1:0]       emitted_base;
    logic [PPF_W-1:0]       emitted_inc;
    logic [PPF_W-1:0]       lim_capped;
    logic [PPF_W-1:0]       lim;
    logic [BUF_W-1:0]       buf_acc;
    logic [HELD_W-1:0]      held_acc;
    logic [BYTE_W-1:0]      byte_in;

    assign pop_ok = pop && !empty;
    assign empty = (oq_count_reg == 2'd0);
    assign pixel_value = oq_reg[oq_rd_reg].pixel_value;
    assign last_pixel = oq_reg[oq_rd_reg].last_pixel;

    // a byte is taken only when the pixel queue has room for its result
    assign take = link.valid && ((oq_count_reg != 2'd2) || pop_ok);

    assign byte_in = link.item.data_byte;

    always_comb
    begin
        lim_capped = (ppf_reg > MAX_FRAME_PIXELS) ? MAX_FRAME_PIXELS : ppf_reg;
        // pairs only in mono12 packed mode
        lim = (mode_reg == FMT_MONO12P) ? {lim_capped[PPF_W-1:1], 1'b0} : lim_capped;

        buf_base = link.item.frame_start ? '0 : buf_reg;
        held_base = link.item.frame_start ? '0 : held_reg;
        phase_base = link.item.frame_start ? PH_FIRST : phase_reg;
        emitted_base = link.item.frame_start ? '0 : emitted_reg;
        emitted_inc = emitted_base + 1'b1;

        buf_acc = buf_base | (BUF_W'(byte_in) << held_base);
        held_acc = held_base + 5'd8;

        buf_next = buf_reg;
        held_next = held_reg;
        phase_next = phase_reg;
        emitted_next = emitted_reg;
        out_push = 1'b0;
        out_item.pixel_value = '0;
        out_item.last_pixel = (emitted_inc == lim);

        if (take)
        begin
            buf_next = buf_base;
            held_next = held_base;
            phase_next = phase_base;
            emitted_next = emitted_base;
            if (emitted_base < lim)
            begin
                if (mode_reg == FMT_LSB_FIRST)
                begin
                    buf_next = buf_acc;
                    held_next = held_acc;
                    if (held_acc >= HELD_W'(bpp_reg))
                    begin
                        out_item.pixel_value = buf_acc[PIX_W-1:0]
                            & (15'h7FFF >> (BPP_MAX - bpp_reg));
                        buf_next = buf_acc >> bpp_reg;
                        held_next = held_acc - HELD_W'(bpp_reg);
                        out_push = 1'b1;
                    end
                end
                else
                begin
                    case (phase_base)
                        PH_SECOND:
                        begin
                            out_item.pixel_value = PIX_W'({buf_base[7:0], byte_in[3:0]});
                            buf_next = BUF_W'(byte_in[7:4]);
                            phase_next = PH_THIRD;
                            out_push = 1'b1;
                        end
                        PH_THIRD:
                        begin
                            out_item.pixel_value = PIX_W'({byte_in, buf_base[3:0]});
                            buf_next = '0;
                            phase_next = PH_FIRST;
                            out_push = 1'b1;
                        end
                        default:
                        begin
                            buf_next = BUF_W'(byte_in);
                            phase_next = PH_SECOND;
                        end
                    endcase
                end
                if (out_push)
                begin
                    emitted_next = emitted_inc;
                end
            end
        end

        mode_next = mode_reg;
        bpp_next = bpp_reg;
        ppf_next = ppf_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_FORMAT_MODE:
                begin
                    mode_next = fmt_mode_t'(cfg_data[0]);
                    buf_next = '0;
                    held_next = '0;
                    phase_next = PH_FIRST;
                end
                REG_BITS_PER_PIXEL:
                begin
                    if (cfg_data[BPP_W-1:0] inside {[BPP_MIN:BPP_MAX]})
                    begin
                        bpp_next = cfg_data[BPP_W-1:0];
                    end
                end
                REG_PIXELS_PER_FRAME:
                begin
                    ppf_next = cfg_data;
                end
                default:
                begin
                end
            endcase
        end

        oq_wr_next = out_push ? ~oq_wr_reg : oq_wr_reg;
        oq_rd_next = pop_ok ? ~oq_rd_reg : oq_rd_reg;
        oq_count_next = oq_count_reg;
        if (out_push && !pop_ok)
        begin
            oq_count_next = oq_count_reg + 1'b1;
        end
        else if (pop_ok && !out_push)
        begin
            oq_count_next = oq_count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= FMT_LSB_FIRST;
            bpp_reg <= BPP_RESET;
            ppf_reg <= '0;
            buf_reg <= '0;
            held_reg <= '0;
            phase_reg <= PH_FIRST;
            emitted_reg <= '0;
            oq_wr_reg <= 1'b0;
            oq_rd_reg <= 1'b0;
            oq_count_reg <= '0;
        end
        else
        begin
            mode_reg <= mode_next;
            bpp_reg <= bpp_next;
            ppf_reg <= ppf_next;
            buf_reg <= buf_next;
            held_reg <= held_next;
            phase_reg <= phase_next;
            emitted_reg <= emitted_next;
            oq_wr_reg <= oq_wr_next;
            oq_rd_reg <= oq_rd_next;
            oq_count_reg <= oq_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_push)
        begin
            oq_reg[oq_wr_reg] <= out_item;
        end
    end

    // at most fourteen bits wait between bytes, so the buffer never overflows
    `PPU_ASSERT(a_held_bound, held_reg <= 5'd14)
    // a pixel is only produced into a free queue slot
    `PPU_ASSERT(a_no_overrun, !out_push || oq_count_reg != 2'd2 || pop_ok)
    // lsb-first pixels never carry bits above the configured width
    `PPU_ASSERT_NEXT(a_pix_width, out_push && mode_reg == FMT_LSB_FIRST && oq_count_reg == 2'd0,
        (pixel_value >> bpp_reg) == '0)

endmodule

@@ hw/rtl/packed_pixel_unpacker.sv @@
// packed pixel unpacker: byte queue in front, unpack core and pixel queue behind
// each byte is registered in the byte queue and each pixel in the pixel queue
// throughput: one byte accepted every cycle while not full, at most one pixel per byte
// the byte queue holds four items and the pixel queue two, so either side may stall alone
// reset clears both queues and all unpack state and loads the register reset values
// configuration writes are always ready and act in the cycle they are taken
module packed_pixel_unpacker
    import ppu_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  logic [BYTE_W-1:0]    data_byte,
    input  logic                 frame_start,
    output logic                 empty,
    input  logic                 pop,
    output logic [PIX_W-1:0]     pixel_value,
    output logic                 last_pixel,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [PPF_W-1:0]     cfg_data
);

    byte_link_t link;
    logic       take;

    assign cfg_ready = 1'b1;

    ppu_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .data_byte   (data_byte),
        .frame_start (frame_start),
        .link        (link),
        .take        (take)
    );

    ppu_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .link        (link),
        .take        (take),
        .cfg_valid   (cfg_valid),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .empty       (empty),
        .pop         (pop),
        .pixel_value (pixel_value),
        .last_pixel  (last_pixel)
    );

endmodule

@@ bench/tb_packed_pixel_unpacker.sv @@
// self-checking testbench for the packed pixel unpacker, byte queue in and pixel queue out
module tb_packed_pixel_unpacker;
    timeunit 1ns;
    timeprecision 1ps;

    import ppu_pkg::*;

    localparam int unsigned RANDOM_ITEMS = 1500;
    localparam int unsigned PRESSURE_PHASE = 3;
    localparam int unsigned SETTLE_CYCLES = 16;
    localparam int unsigned LONG_HOLD = 80;
    localparam int unsigned CYCLE_LIMIT = 1_000_000;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    typedef enum logic [1:0] {
        ROW_CFG,
        ROW_PREDICT,
        ROW_NO_PIXEL,
        ROW_PIXEL
    } row_kind_t;

    typedef struct packed {
        row_kind_t             kind;
        logic [CFG_IDX_W-1:0]  idx;
        logic [PPF_W-1:0]      value;
        logic [BYTE_W-1:0]     dbyte;
        logic                  fs;
        logic [PIX_W-1:0]      pix;
        logic                  last;
    } script_row_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 push;
    logic                 full;
    logic [BYTE_W-1:0]    data_byte;
    logic                 frame_start;
    logic                 empty;
    logic                 pop;
    logic [PIX_W-1:0]     pixel_value;
    logic                 last_pixel;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [PPF_W-1:0]     cfg_data;

    // local copy of the unpacker state and its registers
    fmt_mode_t        cur_mode;
    logic [BPP_W-1:0] cur_width;
    logic [PPF_W-1:0] frame_len;
    logic [BUF_W-1:0] bit_store;
    logic [HELD_W-1:0] held_bits;
    pair_phase_t      triple_pos;
    logic [PPF_W-1:0] frame_pixels;

    pixel_item_t pixels_due[$];
    script_row_t script[$];
    int unsigned mismatches = 0;
    int unsigned cycles = 0;
    bit          tx_gaps = 1'b1;
    bit          long_hold_req = 1'b0;

    packed_pixel_unpacker dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .data_byte   (data_byte),
        .frame_start (frame_start),
        .empty       (empty),
        .pop         (pop),
        .pixel_value (pixel_value),
        .last_pixel  (last_pixel),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic logic [PPF_W-1:0] frame_limit();
        logic [PPF_W-1:0] lim;
        lim = (frame_len > MAX_FRAME_PIXELS) ? MAX_FRAME_PIXELS : frame_len;
        // an unpaired last pixel never comes out in mono12 packing
        if (cur_mode == FMT_MONO12P)
            lim[0] = 1'b0;
        return lim;
    endfunction

    function automatic void unpack_byte(input logic [BYTE_W-1:0] b, input logic fs,
                                        output logic consumed, output logic produced,
                                        output pixel_item_t px);
        logic [PPF_W-1:0] lim;
        logic [31:0]      widened;
        logic [PIX_W-1:0] pix;
        consumed = 1'b0;
        produced = 1'b0;
        px = '0;
        pix = '0;
        if (fs)
        begin
            bit_store = '0;
            held_bits = '0;
            triple_pos = PH_FIRST;
            frame_pixels = '0;
        end
        lim = frame_limit();
        if (frame_pixels >= lim)
            return;
        consumed = 1'b1;
        if (cur_mode == FMT_LSB_FIRST)
        begin
            widened = 32'(bit_store) | (32'(b) << held_bits);
            bit_store = widened[BUF_W-1:0];
            held_bits = held_bits + 5'd8;
            if (held_bits >= 5'(cur_width))
            begin
                pix = PIX_W'(bit_store & ((22'd1 << cur_width) - 22'd1));
                bit_store = bit_store >> cur_width;
                held_bits = held_bits - 5'(cur_width);
                produced = 1'b1;
            end
        end
        else
        begin
            case (triple_pos)
                PH_SECOND:
                begin
                    pix = {3'b000, bit_store[7:0], b[3:0]};
                    bit_store = BUF_W'(b[7:4]);
                    triple_pos = PH_THIRD;
                    produced = 1'b1;
                end
                PH_THIRD:
                begin
                    pix = {3'b000, b, bit_store[3:0]};
                    bit_store = '0;
                    triple_pos = PH_FIRST;
                    produced = 1'b1;
                end
                default:
                begin
                    bit_store = BUF_W'(b);
                    triple_pos = PH_SECOND;
                end
            endcase
        end
        if (produced)
        begin
            frame_pixels = frame_pixels + 1'b1;
            px.pixel_value = pix;
            px.last_pixel = (frame_pixels == lim);
        end
    endfunction

    // pushed low only ahead of a gap, so a back-to-back item keeps push high
    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic fs);
        int unsigned gap;
        gap = tx_gaps ? $urandom_range(0, 11) : 0;
        if (gap != 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push <= 1'b1;
        data_byte <= b;
        frame_start <= fs;
        @(posedge clk);
        while (full)
            @(posedge clk);
    endtask

    task automatic feed_byte(input logic [BYTE_W-1:0] b, input logic fs,
                             output logic consumed);
        logic        produced;
        pixel_item_t px;
        send_byte(b, fs);
        unpack_byte(b, fs, consumed, produced, px);
        if (produced)
            pixels_due.push_back(px);
    endtask

    // bytes that give no pixel may still sit in the byte queue, so allow them to drain
    task automatic settle();
        push <= 1'b0;
        while (pixels_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_register(input logic [CFG_IDX_W-1:0] idx, input logic [PPF_W-1:0] val);
        settle();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            REG_FORMAT_MODE:
            begin
                cur_mode = fmt_mode_t'(val[0]);
                bit_store = '0;
                held_bits = '0;
                triple_pos = PH_FIRST;
            end
            REG_BITS_PER_PIXEL:
                if (val[BPP_W-1:0] >= BPP_MIN && val[BPP_W-1:0] <= BPP_MAX)
                    cur_width = val[BPP_W-1:0];
            REG_PIXELS_PER_FRAME:
                frame_len = val;
            default: ;
        endcase
    endtask

    initial
    begin : pixel_sink
        int unsigned hold;
        int unsigned taken;
        bit          rx_gaps;
        pixel_item_t due;
        taken = 0;
        rx_gaps = 1'b1;
        pop <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            hold = rx_gaps ? $urandom_range(0, 11) : 0;
            if (long_hold_req)
            begin
                hold = hold + LONG_HOLD;
                long_hold_req = 1'b0;
            end
            if (hold != 0)
            begin
                pop <= 1'b0;
                repeat (hold) @(posedge clk);
            end
            pop <= 1'b1;
            @(posedge clk);
            while (empty)
                @(posedge clk);
            if (pixels_due.size() == 0)
            begin
                $error("pixel item %0h arrived with none expected", pixel_value);
                mismatches++;
            end
            else
            begin
                due = pixels_due.pop_front();
                if (pixel_value !== due.pixel_value)
                begin
                    $error("pixel_value: expected %0h, got %0h", due.pixel_value, pixel_value);
                    mismatches++;
                end
                if (last_pixel !== due.last_pixel)
                begin
                    $error("last_pixel: expected %0b, got %0b", due.last_pixel, last_pixel);
                    mismatches++;
                end
            end
            taken++;
            // switch between stalling and full-rate stretches now and then
            if (taken % 40 == 0)
                rx_gaps = ($urandom_range(0, 2) != 0);
        end
    end

    initial
    begin : stimulus
        script_row_t      row;
        logic             consumed;
        logic             produced;
        logic             start;
        pixel_item_t      px;
        logic [PPF_W-1:0] len_pick;
        int unsigned      fed;
        int unsigned      phase;
        int unsigned      frames;
        int unsigned      budget;

        push <= 1'b0;
        data_byte <= '0;
        frame_start <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;
        cur_mode = FMT_LSB_FIRST;
        cur_width = BPP_RESET;
        frame_len = '0;
        bit_store = '0;
        held_bits = '0;
        triple_pos = PH_FIRST;
        frame_pixels = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // frame length of zero after reset: everything ignored
        script.push_back('{ROW_NO_PIXEL, '0, '0, 8'hA5, 1'b1, '0, 1'b0});
        script.push_back('{ROW_CFG, REG_PIXELS_PER_FRAME, 25'd4, '0, 1'b0, '0, 1'b0});
        script.push_back('{ROW_NO_PIXEL, '0, '0, 8'hFF, 1'b1, '0, 1'b0});
        script.push_back('{ROW_PIXEL, '0, '0, 8'hFF, 1'b0, 15'h0FFF, 1'b0});
        script.push_back('{ROW_PIXEL, '0, '0, 8'hFF, 1'b0, 15'h0FFF, 1'b0});
        script.push_back('{ROW_NO_PIXEL, '0, '0, 8'h00, 1'b0, '0, 1'b0});
        script.push_back('{ROW_PIXEL, '0, '0, 8'h00, 1'b0, 15'h0000, 1'b0});
        script.push_back('{ROW_PIXEL, '0, '0, 8'h00, 1'b0, 15'h0000, 1'b1});
        // past the end of the frame
        script.push_back('{ROW_NO_PIXEL, '0, '0, 8'h3C, 1'b0, '0, 1'b0});
        script.push_back('{ROW_CFG, REG_BITS_PER_PIXEL, 25'd15, '0, 1'b0, '0, 1'b0});
        // out-of-range widths are rejected
        script.push_back('{ROW_CFG, REG_BITS_PER_PIXEL, 25'h1FFFFF8, '0, 1'b0, '0, 1'b0});
        script.push_back('{ROW_CFG, REG_BITS_PER_PIXEL, 25'd0, '0, 1'b0, '0, 1'b0});
        script.push_back('{ROW_NO_PIXEL, '0, '0, 8'hFF, 1'b1, '0, 1'b0});
        script.push_back('{ROW_PIXEL, '0, '0, 8'hFF, 1'b0, 15'h7FFF, 1'b0});
        // width change in mid-frame keeps the held bit
        script.push_back('{ROW_CFG, REG_BITS_PER_PIXEL, 25'd9, '0, 1'b0, '0, 1'b0});
        script.push_back('{ROW_PREDICT, '0, '0, 8'h5A, 1'b0, '0, 1'b0});
        script.push_back('{ROW_PREDICT, '0, '0, 8'hC3, 1'b0, '0, 1'b0});
        // mode change keeps the pixel count
        script.push_back('{ROW_CFG, REG_FORMAT_MODE, 25'd1, '0, 1'b0, '0, 1'b0});
        script.push_back('{ROW_PREDICT, '0, '0, 8'hAB, 1'b0, '0, 1'b0});
        script.push_back('{ROW_PREDICT, '0, '0, 8'hCD, 1'b0, '0, 1'b0});
        script.push_back('{ROW_PREDICT, '0, '0, 8'hEF, 1'b0, '0, 1'b0});
        // odd frame length in mono12: third pixel never comes
        script.push_back('{ROW_CFG, REG_PIXELS_PER_FRAME, 25'd3, '0, 1'b0, '0, 1'b0});
        script.push_back('{ROW_NO_PIXEL, '0, '0, 8'hFF, 1'b1, '0, 1'b0});
        script.push_back('{ROW_PIXEL, '0, '0, 8'h00, 1'b0, 15'h0FF0, 1'b0});
        script.push_back('{ROW_PIXEL, '0, '0, 8'hFF, 1'b0, 15'h0FF0, 1'b1});
        script.push_back('{ROW_NO_PIXEL, '0, '0, 8'h12, 1'b0, '0, 1'b0});
        script.push_back('{ROW_CFG, REG_UNUSED, 25'h1FFFFFF, '0, 1'b0, '0, 1'b0});
        // frame length above the cap
        script.push_back('{ROW_CFG, REG_PIXELS_PER_FRAME, 25'h1FFFFFF, '0, 1'b0, '0, 1'b0});
        script.push_back('{ROW_PREDICT, '0, '0, 8'h77, 1'b1, '0, 1'b0});
        script.push_back('{ROW_PREDICT, '0, '0, 8'h88, 1'b0, '0, 1'b0});
        // restart in the middle of a byte triple
        script.push_back('{ROW_PREDICT, '0, '0, 8'h99, 1'b1, '0, 1'b0});
        script.push_back('{ROW_PREDICT, '0, '0, 8'hAA, 1'b0, '0, 1'b0});
        script.push_back('{ROW_CFG, REG_FORMAT_MODE, 25'd0, '0, 1'b0, '0, 1'b0});
        script.push_back('{ROW_PREDICT, '0, '0, 8'h0F, 1'b0, '0, 1'b0});
        script.push_back('{ROW_PREDICT, '0, '0, 8'hF0, 1'b0, '0, 1'b0});

        foreach (script[i])
        begin
            row = script[i];
            if (row.kind == ROW_CFG)
                set_register(row.idx, row.value);
            else
            begin
                send_byte(row.dbyte, row.fs);
                unpack_byte(row.dbyte, row.fs, consumed, produced, px);
                if (row.kind == ROW_PIXEL)
                    pixels_due.push_back('{row.pix, row.last});
                else if (row.kind == ROW_PREDICT && produced)
                    pixels_due.push_back(px);
            end
        end

        fed = 0;
        phase = 0;
        while (fed < RANDOM_ITEMS)
        begin
            phase++;
            if (phase == PRESSURE_PHASE)
            begin
                // long frame at full rate while the pixel side holds off
                set_register(REG_FORMAT_MODE, 25'(FMT_LSB_FIRST));
                set_register(REG_BITS_PER_PIXEL, 25'(BPP_MIN));
                set_register(REG_PIXELS_PER_FRAME, 25'd300);
                tx_gaps = 1'b0;
                long_hold_req = 1'b1;
            end
            else
            begin
                if ($urandom_range(0, 2) == 0)
                    set_register(REG_FORMAT_MODE, PPF_W'($urandom));
                if ($urandom_range(0, 2) == 0)
                    set_register(REG_BITS_PER_PIXEL, PPF_W'($urandom));
                if ($urandom_range(0, 1) == 0)
                begin
                    case ($urandom_range(0, 9))
                        0: len_pick = '0;
                        1: len_pick = {1'b1, 24'($urandom)};
                        2: len_pick = PPF_W'($urandom_range(25, 200));
                        default: len_pick = PPF_W'($urandom_range(1, 24));
                    endcase
                    set_register(REG_PIXELS_PER_FRAME, len_pick);
                end
                if ($urandom_range(0, 15) == 0)
                    set_register(REG_UNUSED, PPF_W'($urandom));
                tx_gaps = ($urandom_range(0, 3) != 0);
            end

            frames = (phase == PRESSURE_PHASE) ? 1 : $urandom_range(1, 4);
            for (int f = 0; f < frames; f++)
            begin
                // now and then carry on the old frame under the new settings
                start = (f != 0 || phase == PRESSURE_PHASE || $urandom_range(0, 5) != 0);
                budget = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 8) : 400;
                for (int n = 0; n < budget; n++)
                begin
                    if (n != 0 && (frame_pixels >= frame_limit() || fed >= RANDOM_ITEMS))
                        break;
                    feed_byte(8'($urandom), (n == 0) ? start : ($urandom_range(0, 39) == 0),
                              consumed);
                    fed += consumed;
                end
                repeat ($urandom_range(0, 2))
                begin
                    feed_byte(8'($urandom), 1'b0, consumed);
                    fed += consumed;
                end
            end
        end

        settle();
        if (mismatches == 0 && pixels_due.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
